/* hdl/aabb_query_unit_macros.svh */
// Assertion macros shared by the box query unit.
`ifndef AABB_QUERY_UNIT_MACROS_SVH
`define AABB_QUERY_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AQU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define AQU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/aqu_pkg.sv */
// Shared types and constants of the box query unit.
`default_nettype none

package aqu_pkg;

  // Default coordinate width (signed Q16.16).
  localparam int COORD_BITS_DEF = 32;

  // Number of register stages from input to output.
  localparam int NUM_STAGES = 6;

  // Width of the configuration register index.
  localparam int CFG_IDX_BITS = 3;

  // Query kinds.
  typedef enum logic [1:0] {
    KIND_BOX_OVERLAP    = 2'd0,
    KIND_POINT_IN       = 2'd1,
    KIND_SPHERE_OVERLAP = 2'd2,
    KIND_SPHERE_IN      = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  // Load enables of the pipeline stages, one per stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_ld_t;

  // Per-item decision flags carried down the pipeline.
  typedef struct packed {
    kind_t kind;
    logic  degen;
    logic  box_hit;
    logic  point_hit;
    logic  gaps_ok;
    logic  inner_ok;
  } query_flags_t;

endpackage

`default_nettype wire

/* hdl/aqu_front.sv */
// Stages one and two: per-axis compares, gaps, extent, centre and decision flags.
`default_nettype none

module aqu_front
  import aqu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire stage_ld_t                   ld,
  input  wire logic [1:0]                  kind,
  input  wire logic [2:0][COORD_BITS-1:0]  point,
  input  wire logic [2:0][COORD_BITS-1:0]  far,
  input  wire logic [COORD_BITS-2:0]       radius,
  input  wire logic [2:0][COORD_BITS-1:0]  box_min,
  input  wire logic [2:0][COORD_BITS-1:0]  box_max,
  output query_flags_t                     flags,
  output logic [2:0][COORD_BITS-2:0]       gap,
  output logic [COORD_BITS-2:0]            rad,
  output logic [2:0][COORD_BITS-1:0]       extent,
  output logic [2:0][COORD_BITS-1:0]       center
);

  localparam int RW = COORD_BITS - 1;

  // Stage one combinational signals.
  logic [2:0]                 lo_le_f;
  logic [2:0]                 p_le_hi;
  logic [2:0]                 lo_le_p;
  logic [2:0]                 deg_ax;
  logic [2:0][COORD_BITS-1:0] gap_lo;
  logic [2:0][COORD_BITS-1:0] gap_hi;
  logic [2:0][COORD_BITS:0]   csum;

  logic [1:0]                 s1_kind_nxt, s1_kind_r;
  logic [RW-1:0]              s1_rad_r;
  logic [2:0][COORD_BITS-1:0] s1_gap_nxt, s1_gap_r;
  logic [2:0][COORD_BITS-1:0] s1_dlo_nxt, s1_dlo_r;
  logic [2:0][COORD_BITS-1:0] s1_dhi_nxt, s1_dhi_r;
  logic                       s1_degen_nxt, s1_degen_r;
  logic                       s1_box_nxt, s1_box_r;
  logic                       s1_pt_nxt, s1_pt_r;
  logic [2:0][COORD_BITS-1:0] s1_ext_nxt, s1_ext_r;
  logic [2:0][COORD_BITS-1:0] s1_ctr_nxt, s1_ctr_r;

  // Stage two combinational signals.
  logic [2:0]                 gap_ok;
  logic [2:0]                 in_ok;
  query_flags_t               s2_flags_nxt, s2_flags_r;
  logic [2:0][RW-1:0]         s2_gap_nxt, s2_gap_r;
  logic [RW-1:0]              s2_rad_r;
  logic [2:0][COORD_BITS-1:0] s2_ext_r;
  logic [2:0][COORD_BITS-1:0] s2_ctr_r;

  // Per-axis compares and differences against the configured box.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_le_f[i] = $signed(box_min[i]) <= $signed(far[i]);
      p_le_hi[i] = $signed(point[i]) <= $signed(box_max[i]);
      lo_le_p[i] = $signed(box_min[i]) <= $signed(point[i]);
      deg_ax[i]  = $signed(box_max[i]) <= $signed(box_min[i]);
      gap_lo[i]  = box_min[i] - point[i];
      gap_hi[i]  = point[i] - box_max[i];
      s1_dlo_nxt[i] = point[i] - box_min[i];
      s1_dhi_nxt[i] = box_max[i] - point[i];
      csum[i] = {box_min[i][COORD_BITS-1], box_min[i]}
              + {box_max[i][COORD_BITS-1], box_max[i]};
    end
  end

  // Stage one results: gap to the box, overlap flags, extent and centre.
  always_comb begin
    s1_kind_nxt  = kind;
    s1_degen_nxt = |deg_ax;
    s1_box_nxt   = &(lo_le_f & p_le_hi);
    s1_pt_nxt    = &(lo_le_p & p_le_hi);
    for (int i = 0; i < 3; i++) begin
      if (!lo_le_p[i]) begin
        s1_gap_nxt[i] = gap_lo[i];
      end else if (!p_le_hi[i]) begin
        s1_gap_nxt[i] = gap_hi[i];
      end else begin
        s1_gap_nxt[i] = '0;
      end
      s1_ext_nxt[i] = s1_degen_nxt ? '0 : s1_dhi_nxt[i] + s1_dlo_nxt[i];
      s1_ctr_nxt[i] = s1_degen_nxt ? '0 : csum[i][COORD_BITS:1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_rad_r   <= radius;
      s1_gap_r   <= s1_gap_nxt;
      s1_dlo_r   <= s1_dlo_nxt;
      s1_dhi_r   <= s1_dhi_nxt;
      s1_degen_r <= s1_degen_nxt;
      s1_box_r   <= s1_box_nxt;
      s1_pt_r    <= s1_pt_nxt;
      s1_ext_r   <= s1_ext_nxt;
      s1_ctr_r   <= s1_ctr_nxt;
    end
  end

  // Stage two: radius compares for both sphere tests.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gap_ok[i] = s1_gap_r[i] <= {1'b0, s1_rad_r};
      in_ok[i]  = (s1_dlo_r[i] >= {1'b0, s1_rad_r}) && (s1_dhi_r[i] >= {1'b0, s1_rad_r});
      // A gap above the radius already fails, so its top bit may be dropped.
      s2_gap_nxt[i] = s1_gap_r[i][RW-1:0];
    end
    s2_flags_nxt.kind      = kind_t'(s1_kind_r);
    s2_flags_nxt.degen     = s1_degen_r;
    s2_flags_nxt.box_hit   = s1_box_r;
    s2_flags_nxt.point_hit = s1_pt_r;
    s2_flags_nxt.gaps_ok   = (&gap_ok) && !s1_degen_r;
    s2_flags_nxt.inner_ok  = s1_pt_r && (&in_ok) && !s1_degen_r;
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      s2_flags_r <= s2_flags_nxt;
      s2_gap_r   <= s2_gap_nxt;
      s2_rad_r   <= s1_rad_r;
      s2_ext_r   <= s1_ext_r;
      s2_ctr_r   <= s1_ctr_r;
    end
  end

  assign flags  = s2_flags_r;
  assign gap    = s2_gap_r;
  assign rad    = s2_rad_r;
  assign extent = s2_ext_r;
  assign center = s2_ctr_r;

endmodule

`default_nettype wire

/* hdl/aqu_square.sv */
// Stages three and four: a square built from three half-width partial products.
`default_nettype none

module aqu_square
  import aqu_pkg::*;
#(
  parameter int VAL_BITS = COORD_BITS_DEF - 1
) (
  input  wire logic                    clk,
  input  wire stage_ld_t               ld,
  input  wire logic [VAL_BITS-1:0]     value,
  output logic [2*VAL_BITS-1:0]        square
);

  localparam int LB = (VAL_BITS + 1) / 2;
  localparam int HB = VAL_BITS - LB;
  localparam int SW = 2 * VAL_BITS;

  logic [LB-1:0]       lo;
  logic [HB-1:0]       hi;
  logic [2*LB-1:0]     pll_nxt, pll_r;
  logic [VAL_BITS-1:0] plh_nxt, plh_r;
  logic [2*HB-1:0]     phh_nxt, phh_r;
  logic [SW-1:0]       sq_nxt, sq_r;

  // Stage three: partial products of the low and high halves.
  always_comb begin
    lo      = value[LB-1:0];
    hi      = value[VAL_BITS-1:LB];
    pll_nxt = (2*LB)'(lo) * (2*LB)'(lo);
    plh_nxt = VAL_BITS'(lo) * VAL_BITS'(hi);
    phh_nxt = (2*HB)'(hi) * (2*HB)'(hi);
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      pll_r <= pll_nxt;
      plh_r <= plh_nxt;
      phh_r <= phh_nxt;
    end
  end

  // Stage four: the two square terms abut, the cross term is added twice over.
  always_comb begin
    sq_nxt = {phh_r, pll_r} + (SW'(plh_r) << (LB + 1));
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      sq_r <= sq_nxt;
    end
  end

  assign square = sq_r;

endmodule

`default_nettype wire

/* hdl/aqu_back.sv */
// Stages three to six: side data delay, distance sum, final compare and result register.
`default_nettype none

module aqu_back
  import aqu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire stage_ld_t                     ld,
  input  wire query_flags_t                  flags,
  input  wire logic [2:0][COORD_BITS-1:0]    extent,
  input  wire logic [2:0][COORD_BITS-1:0]    center,
  input  wire logic [2:0][2*COORD_BITS-3:0]  gap_sq,
  input  wire logic [2*COORD_BITS-3:0]       rad_sq,
  output logic                               hit,
  output logic                               degen,
  output logic [2:0][COORD_BITS-1:0]         extent_out,
  output logic [2:0][COORD_BITS-1:0]         center_out
);

  localparam int SW = 2 * (COORD_BITS - 1);
  localparam int DW = SW + 2;

  query_flags_t               s3_flags_r, s4_flags_r, s5_flags_r;
  logic [2:0][COORD_BITS-1:0] s3_ext_r, s4_ext_r, s5_ext_r;
  logic [2:0][COORD_BITS-1:0] s3_ctr_r, s4_ctr_r, s5_ctr_r;
  logic [DW-1:0]              d2_nxt, s5_d2_r;
  logic [SW-1:0]              s5_r2_r;
  logic                       hit_nxt, hit_r;
  logic                       degen_r;
  logic [2:0][COORD_BITS-1:0] ext_r;
  logic [2:0][COORD_BITS-1:0] ctr_r;

  // Side data follows the squaring stages.
  always_ff @(posedge clk) begin
    if (ld.s3) begin
      s3_flags_r <= flags;
      s3_ext_r   <= extent;
      s3_ctr_r   <= center;
    end
    if (ld.s4) begin
      s4_flags_r <= s3_flags_r;
      s4_ext_r   <= s3_ext_r;
      s4_ctr_r   <= s3_ctr_r;
    end
  end

  // Stage five: squared distance from the sphere centre to the box.
  always_comb begin
    d2_nxt = DW'(gap_sq[0]) + DW'(gap_sq[1]) + DW'(gap_sq[2]);
  end

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      s5_flags_r <= s4_flags_r;
      s5_ext_r   <= s4_ext_r;
      s5_ctr_r   <= s4_ctr_r;
      s5_d2_r    <= d2_nxt;
      s5_r2_r    <= rad_sq;
    end
  end

  // Stage six: pick the answer for the query kind.
  always_comb begin
    unique case (s5_flags_r.kind)
      KIND_BOX_OVERLAP:    hit_nxt = s5_flags_r.box_hit;
      KIND_POINT_IN:       hit_nxt = s5_flags_r.point_hit;
      KIND_SPHERE_OVERLAP: hit_nxt = s5_flags_r.gaps_ok && (s5_d2_r <= DW'(s5_r2_r));
      KIND_SPHERE_IN:      hit_nxt = s5_flags_r.inner_ok;
      default:             hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.s6) begin
      hit_r   <= hit_nxt;
      degen_r <= s5_flags_r.degen;
      ext_r   <= s5_ext_r;
      ctr_r   <= s5_ctr_r;
    end
  end

  assign hit        = hit_r;
  assign degen      = degen_r;
  assign extent_out = ext_r;
  assign center_out = ctr_r;

endmodule

`default_nettype wire

/* hdl/aabb_query_unit.sv */
// Top level of the box query unit: configuration, pipeline control and checks.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   kind, point, far corner, radius
//   out_      output     out_valid / out_stall hit, degenerate, extent, centre
//   cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// Six register stages; one query enters per cycle while in_stall is low.
// The depth is set by the squaring path (compare, radius test, two multiply
// stages, sum, final compare).
// A stall on the output fills empty stages first and reaches in_stall only
// when every stage holds an item. Reset empties the pipeline and clears the
// box corners to zero; in_stall is high while reset is held.
`default_nettype none

module aabb_query_unit
  import aqu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Query channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_kind,
  input  wire logic [COORD_BITS-1:0]    in_point_x,
  input  wire logic [COORD_BITS-1:0]    in_point_y,
  input  wire logic [COORD_BITS-1:0]    in_point_z,
  input  wire logic [COORD_BITS-1:0]    in_far_x,
  input  wire logic [COORD_BITS-1:0]    in_far_y,
  input  wire logic [COORD_BITS-1:0]    in_far_z,
  input  wire logic [COORD_BITS-2:0]    in_radius,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_hit,
  output logic                          out_degenerate,
  output logic [COORD_BITS-1:0]         out_extent_x,
  output logic [COORD_BITS-1:0]         out_extent_y,
  output logic [COORD_BITS-1:0]         out_extent_z,
  output logic [COORD_BITS-1:0]         out_center_x,
  output logic [COORD_BITS-1:0]         out_center_y,
  output logic [COORD_BITS-1:0]         out_center_z,
  // Configuration port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0]    cfg_wdata
);

  `include "aabb_query_unit_macros.svh"

  localparam int RW = COORD_BITS - 1;

  logic [2:0][COORD_BITS-1:0] box_min_r;
  logic [2:0][COORD_BITS-1:0] box_max_r;
  logic [NUM_STAGES-1:0]      valid_nxt, valid_r;
  logic [NUM_STAGES-1:0]      rdy;
  stage_ld_t                  ld;

  logic [2:0][COORD_BITS-1:0] point;
  logic [2:0][COORD_BITS-1:0] far;
  query_flags_t               s2_flags;
  logic [2:0][RW-1:0]         s2_gap;
  logic [RW-1:0]              s2_rad;
  logic [2:0][COORD_BITS-1:0] s2_ext;
  logic [2:0][COORD_BITS-1:0] s2_ctr;
  logic [2:0][2*RW-1:0]       gap_sq;
  logic [2*RW-1:0]            rad_sq;
  logic [2:0][COORD_BITS-1:0] ext_out;
  logic [2:0][COORD_BITS-1:0] ctr_out;

  // Box corner registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= '0;
      box_max_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: box_min_r[0] <= cfg_wdata;
        REG_MIN_Y: box_min_r[1] <= cfg_wdata;
        REG_MIN_Z: box_min_r[2] <= cfg_wdata;
        REG_MAX_X: box_max_r[0] <= cfg_wdata;
        REG_MAX_Y: box_max_r[1] <= cfg_wdata;
        REG_MAX_Z: box_max_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage takes new data when it is empty or the stage after it moves on.
  always_comb begin
    rdy[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    ld.s1 = rdy[0];
    ld.s2 = rdy[1];
    ld.s3 = rdy[2];
    ld.s4 = rdy[3];
    ld.s5 = rdy[4];
    ld.s6 = rdy[5];
  end

  assign in_stall  = !rdy[0] || !rst_n;
  assign out_valid = valid_r[NUM_STAGES-1];

  assign point = {in_point_z, in_point_y, in_point_x};
  assign far   = {in_far_z, in_far_y, in_far_x};

  // Compares, gaps and side data.
  aqu_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .ld      (ld),
    .kind    (in_kind),
    .point   (point),
    .far     (far),
    .radius  (in_radius),
    .box_min (box_min_r),
    .box_max (box_max_r),
    .flags   (s2_flags),
    .gap     (s2_gap),
    .rad     (s2_rad),
    .extent  (s2_ext),
    .center  (s2_ctr)
  );

  // Squares of the three gaps.
  for (genvar i = 0; i < 3; i++) begin : g_gap_sq
    aqu_square #(
      .VAL_BITS (RW)
    ) u_sq (
      .clk    (clk),
      .ld     (ld),
      .value  (s2_gap[i]),
      .square (gap_sq[i])
    );
  end

  // Square of the radius.
  aqu_square #(
    .VAL_BITS (RW)
  ) u_rad_sq (
    .clk    (clk),
    .ld     (ld),
    .value  (s2_rad),
    .square (rad_sq)
  );

  // Distance sum, final decision and result register.
  aqu_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .ld         (ld),
    .flags      (s2_flags),
    .extent     (s2_ext),
    .center     (s2_ctr),
    .gap_sq     (gap_sq),
    .rad_sq     (rad_sq),
    .hit        (out_hit),
    .degen      (out_degenerate),
    .extent_out (ext_out),
    .center_out (ctr_out)
  );

  assign out_extent_x = ext_out[0];
  assign out_extent_y = ext_out[1];
  assign out_extent_z = ext_out[2];
  assign out_center_x = ctr_out[0];
  assign out_center_y = ctr_out[1];
  assign out_center_z = ctr_out[2];

  // The input is only held off when every stage is occupied, or in reset.
  `AQU_ASSERT(a_stall_only_when_full, !in_stall || !rst_n || (&valid_r), "input stalled with an empty stage")
  // A transfer on the input always lands in the first stage.
  `AQU_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, valid_r[0], "accepted query was lost")
  // A degenerate box reports zero extent and centre.
  `AQU_ASSERT(a_degen_zero, !(out_valid && out_degenerate) || ((ext_out == '0) && (ctr_out == '0)), "degenerate box with nonzero extent or centre")

endmodule

`default_nettype wire
